// ===== src/pmsp_pkg.sv =====
// shared types, character codes and helper functions for the permission mode string parser
`timescale 1ns / 1ps
package pmsp_pkg;

    localparam int unsigned MODE_W  = 9;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 16;

    localparam logic [CNT_W-1:0]  CNT_MAX   = 4'd15;
    localparam logic [CNT_W-1:0]  LEN_OCTAL = 4'd3;
    localparam logic [CNT_W-1:0]  LEN_LONG  = 4'd9;
    localparam logic [MODE_W-1:0] MODE_ALL  = 9'o777;

    localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
    localparam logic [CHAR_W-1:0] CH_W     = 8'h77;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3d;
    localparam logic [CHAR_W-1:0] CH_U     = 8'h75;
    localparam logic [CHAR_W-1:0] CH_G     = 8'h67;
    localparam logic [CHAR_W-1:0] CH_O     = 8'h6f;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_FORMAT = 2'd1,
        ST_BAD_OP     = 2'd2,
        ST_BAD_PERM   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2,
        OP_SET  = 2'd3
    } t_op;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [MODE_W-1:0] cur_mode;
        logic              last;
    } t_item;

    typedef struct packed {
        logic [MODE_W-1:0] res_mode;
        t_status           status;
    } t_result;

    // copy a 3-bit rwx group into each selected class (u=4, g=2, o=1)
    function automatic logic [MODE_W-1:0] spread(input logic [2:0] cls, input logic [2:0] bits);
        spread = {(cls[2] ? bits : 3'b000), (cls[1] ? bits : 3'b000), (cls[0] ? bits : 3'b000)};
    endfunction

    // letter expected at a position of the rwx form
    function automatic logic [CHAR_W-1:0] want_char(input logic [CNT_W-1:0] pos);
        case (pos) inside
            4'd0, 4'd3, 4'd6: want_char = CH_R;
            4'd1, 4'd4, 4'd7: want_char = CH_W;
            default:          want_char = CH_X;
        endcase
    endfunction

endpackage

// ===== src/pmsp_core.sv =====
// per-string parser state and combinational result logic for all four mode forms
`timescale 1ns / 1ps
module pmsp_core
    import pmsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output logic    o_res_valid,
    output t_result o_res
);

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [MODE_W-1:0] r_oct_val, n_oct_val;
    logic              r_oct_ok, n_oct_ok;
    logic              r_first_oct, n_first_oct;
    logic [MODE_W-1:0] r_let_bits, n_let_bits;
    logic              r_let_set_ok, n_let_set_ok;
    logic              r_let_pos_ok, n_let_pos_ok;
    logic [MODE_W-1:0] r_bin_bits, n_bin_bits;
    logic              r_bin_ok, n_bin_ok;
    logic              r_sym_phase, n_sym_phase;
    logic [2:0]        r_cls, n_cls;
    t_op               r_op, n_op;
    logic [MODE_W-1:0] r_sym_mode, n_sym_mode;
    t_status           r_sym_err, n_sym_err;

    logic              w_first;
    logic              w_is_oct;
    logic [CNT_W-1:0]  w_cnt_inc;
    logic [CNT_W-1:0]  w_bit_idx;
    logic [2:0]        w_perm;
    logic [CHAR_W-1:0] w_ch;

    assign w_ch      = i_item.ch;
    assign w_first   = (r_cnt == '0);
    assign w_is_oct  = (w_ch >= CH_ZERO) && (w_ch <= CH_SEVEN);
    assign w_cnt_inc = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 4'd1;
    assign w_bit_idx = 4'd8 - r_cnt;

    always_comb begin
        // start of string reloads everything
        n_oct_val    = w_first ? '0 : r_oct_val;
        n_oct_ok     = w_first ? 1'b1 : r_oct_ok;
        n_first_oct  = w_first ? w_is_oct : r_first_oct;
        n_let_bits   = w_first ? '0 : r_let_bits;
        n_let_set_ok = w_first ? 1'b1 : r_let_set_ok;
        n_let_pos_ok = w_first ? 1'b1 : r_let_pos_ok;
        n_bin_bits   = w_first ? '0 : r_bin_bits;
        n_bin_ok     = w_first ? 1'b1 : r_bin_ok;
        n_sym_phase  = w_first ? 1'b0 : r_sym_phase;
        n_cls        = w_first ? 3'b000 : r_cls;
        n_op         = w_first ? OP_NONE : r_op;
        n_sym_mode   = w_first ? i_item.cur_mode : r_sym_mode;
        n_sym_err    = w_first ? ST_OK : r_sym_err;
        w_perm       = 3'b000;

        if (w_is_oct) begin
            n_oct_val = {n_oct_val[5:0], w_ch[2:0]};
        end else begin
            n_oct_ok = 1'b0;
        end

        if (!(w_ch == CH_R || w_ch == CH_W || w_ch == CH_X || w_ch == CH_DASH)) begin
            n_let_set_ok = 1'b0;
        end
        if (r_cnt < LEN_LONG) begin
            if (w_ch != want_char(r_cnt) && w_ch != CH_DASH) begin
                n_let_pos_ok = 1'b0;
            end
            if (w_ch != CH_DASH) begin
                n_let_bits[w_bit_idx] = 1'b1;
            end
            if (w_ch == CH_ONE) begin
                n_bin_bits[w_bit_idx] = 1'b1;
            end
        end
        if (!(w_ch == CH_ZERO || w_ch == CH_ONE)) begin
            n_bin_ok = 1'b0;
        end

        // symbolic path, frozen after the first error
        if (n_sym_err == ST_OK) begin
            if (!n_sym_phase) begin
                if (w_ch == CH_U) begin
                    n_cls[2] = 1'b1;
                end else if (w_ch == CH_G) begin
                    n_cls[1] = 1'b1;
                end else if (w_ch == CH_O) begin
                    n_cls[0] = 1'b1;
                end else if (w_ch == CH_A) begin
                    n_cls = 3'b111;
                end else if (w_ch == CH_PLUS) begin
                    n_op        = OP_ADD;
                    n_sym_phase = 1'b1;
                end else if (w_ch == CH_DASH) begin
                    n_op        = OP_SUB;
                    n_sym_phase = 1'b1;
                end else if (w_ch == CH_EQ) begin
                    n_op        = OP_SET;
                    n_sym_phase = 1'b1;
                    n_sym_mode  = n_sym_mode & ~spread(n_cls, 3'b111);
                end else begin
                    n_sym_err = ST_BAD_OP;
                end
            end else begin
                if (w_ch == CH_R) begin
                    w_perm = 3'b100;
                end else if (w_ch == CH_W) begin
                    w_perm = 3'b010;
                end else if (w_ch == CH_X) begin
                    w_perm = 3'b001;
                end else begin
                    n_sym_err = ST_BAD_PERM;
                end
                if (n_op == OP_SUB) begin
                    n_sym_mode = n_sym_mode & ~spread(n_cls, w_perm);
                end else begin
                    n_sym_mode = n_sym_mode | spread(n_cls, w_perm);
                end
            end
        end

        n_cnt = i_item.last ? '0 : w_cnt_inc;
    end

    // form chosen by final length
    always_comb begin
        o_res.res_mode = '0;
        o_res.status   = ST_OK;
        if (w_cnt_inc == LEN_OCTAL && n_first_oct) begin
            if (n_oct_ok) begin
                o_res.res_mode = n_oct_val;
            end else begin
                o_res.status = ST_BAD_FORMAT;
            end
        end else if (w_cnt_inc == LEN_LONG && n_let_set_ok) begin
            if (n_let_pos_ok) begin
                o_res.res_mode = n_let_bits;
            end else begin
                o_res.status = ST_BAD_FORMAT;
            end
        end else if (w_cnt_inc == LEN_LONG && n_bin_ok) begin
            o_res.res_mode = n_bin_bits;
        end else if (n_sym_err != ST_OK) begin
            o_res.status = n_sym_err;
        end else if (!n_sym_phase) begin
            o_res.status = ST_BAD_OP;
        end else begin
            o_res.res_mode = n_sym_mode & MODE_ALL;
        end
    end

    assign o_res_valid = i_fire && i_item.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_fire) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_oct_val    <= n_oct_val;
            r_oct_ok     <= n_oct_ok;
            r_first_oct  <= n_first_oct;
            r_let_bits   <= n_let_bits;
            r_let_set_ok <= n_let_set_ok;
            r_let_pos_ok <= n_let_pos_ok;
            r_bin_bits   <= n_bin_bits;
            r_bin_ok     <= n_bin_ok;
            r_sym_phase  <= n_sym_phase;
            r_cls        <= n_cls;
            r_op         <= n_op;
            r_sym_mode   <= n_sym_mode;
            r_sym_err    <= n_sym_err;
        end
    end

    a_err_zero_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.status != ST_OK |-> o_res.res_mode == '0)
        else $error("error result carries nonzero mode");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.last |=> r_cnt == '0)
        else $error("count not cleared after last character");

    a_mid_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !i_item.last |=> r_cnt != '0)
        else $error("count lost inside a string");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_cnt))
        else $error("count moved without a character");

endmodule

// ===== src/permission_mode_string_parser_top.sv =====
// Permission mode string parser: one character per transfer in, one mode result per string out.
//
// s_axis carries one character of a mode string per transfer: tdata holds the character and
// the current mode (sampled on the first character only), tlast marks the final character.
// Octal (three digits), positional rwx (nine of "rwx-"), binary (nine of "01") and symbolic
// strings (who letters, one of + - =, then rwx letters) are all tracked at once and the form
// is chosen by length when tlast arrives.
// m_axis returns one transfer per string: the new mode and a status code
// (ok, bad format, bad operator, bad permission set); the mode is zero on error.
// Throughput is one character per cycle while m_axis is not stalled. A result passes through the
// input register and then the result register before it can transfer on m_axis.
// Reset (i_rst_n low, synchronous) drops any held character and result and starts a new string.
// When the receiver stalls, the result register holds; one more character is buffered in the
// input register, then s_axis_tready drops until the result is taken.
`timescale 1ns / 1ps
module permission_mode_string_parser_top
    import pmsp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // ch[7:0], cur_mode[16:8], zero fill
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // res_mode[8:0], status[10:9], zero fill
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;

    logic    w_out_free;
    logic    w_fire;
    logic    w_res_valid;
    t_result w_res;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.ch       <= s_axis_tdata[CHAR_W-1:0];
            r_in.cur_mode <= s_axis_tdata[CHAR_W+MODE_W-1:CHAR_W];
            r_in.last     <= s_axis_tlast;
        end
    end

    pmsp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (r_in),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - MODE_W - STAT_W){1'b0}}, r_out.status, r_out.res_mode};

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the permission mode string parser: stream stimulus, mode prediction
`timescale 1ns / 1ps
module testbench;
    import pmsp_pkg::*;

    typedef struct {
        t_item it;
        bit    drain;
    } t_pending_char;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // ch[7:0], cur_mode[16:8], zero fill
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // res_mode[8:0], status[10:9], zero fill

    t_pending_char char_q[$];
    t_result       mode_results_q[$];
    t_pending_char cur;
    int unsigned   chars_in  = 0;
    int unsigned   chars_out = 0;
    int unsigned   n_err     = 0;

    // predictor state
    logic [CNT_W-1:0]  cnt = '0;
    logic [MODE_W-1:0] oct_val, ltr_bits, bin_bits, sym_mode;
    bit                oct_ok, ltr_set_ok, ltr_pos_ok, bin_ok, sym_rwx, first_oct;
    logic [2:0]        who;
    t_op               op;
    t_status           sym_err;

    permission_mode_string_parser_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [MODE_W-1:0] class_bits(input logic [2:0] cls,
                                                     input logic [2:0] perm);
        logic [MODE_W-1:0] m;
        m = '0;
        for (int k = 0; k < 3; k++)
            if (cls[k]) m |= MODE_W'(perm) << (3 * k);
        return m;
    endfunction

    function automatic bit no_idle();
        return chars_in >= 300 && chars_in < 480;
    endfunction

    task automatic parse_mode_char(input t_item it);
        logic [CNT_W-1:0]  pos;
        logic [CHAR_W-1:0] want;
        logic [MODE_W-1:0] bit_at;
        logic [2:0]        perm;
        bit                is_oct;
        t_result           res;
        pos    = cnt;
        is_oct = it.ch >= CH_ZERO && it.ch <= CH_SEVEN;
        if (pos == 0) begin
            oct_val    = '0;
            oct_ok     = 1'b1;
            ltr_bits   = '0;
            ltr_set_ok = 1'b1;
            ltr_pos_ok = 1'b1;
            bin_bits   = '0;
            bin_ok     = 1'b1;
            sym_rwx    = 1'b0;
            who        = '0;
            op         = OP_NONE;
            sym_mode   = it.cur_mode;
            sym_err    = ST_OK;
            first_oct  = is_oct;
        end
        if (is_oct) oct_val = {oct_val[5:0], it.ch[2:0]};
        else oct_ok = 1'b0;
        if (it.ch != CH_R && it.ch != CH_W && it.ch != CH_X && it.ch != CH_DASH)
            ltr_set_ok = 1'b0;
        if (pos < LEN_LONG) begin
            case (pos % 3)
                0:       want = CH_R;
                1:       want = CH_W;
                default: want = CH_X;
            endcase
            bit_at = MODE_W'(1) << (8 - pos);
            if (it.ch != want && it.ch != CH_DASH) ltr_pos_ok = 1'b0;
            if (it.ch != CH_DASH) ltr_bits |= bit_at;
            if (it.ch == CH_ONE) bin_bits |= bit_at;
        end
        if (it.ch != CH_ZERO && it.ch != CH_ONE) bin_ok = 1'b0;
        // symbolic path stops at its first error
        if (sym_err == ST_OK) begin
            if (!sym_rwx) begin
                case (it.ch)
                    CH_U:    who |= 3'b100;
                    CH_G:    who |= 3'b010;
                    CH_O:    who |= 3'b001;
                    CH_A:    who = 3'b111;
                    CH_PLUS: begin
                        op      = OP_ADD;
                        sym_rwx = 1'b1;
                    end
                    CH_DASH: begin
                        op      = OP_SUB;
                        sym_rwx = 1'b1;
                    end
                    CH_EQ: begin
                        op       = OP_SET;
                        sym_rwx  = 1'b1;
                        sym_mode &= ~class_bits(who, 3'b111);
                    end
                    default: sym_err = ST_BAD_OP;
                endcase
            end else begin
                perm = 3'b000;
                case (it.ch)
                    CH_R:    perm = 3'b100;
                    CH_W:    perm = 3'b010;
                    CH_X:    perm = 3'b001;
                    default: sym_err = ST_BAD_PERM;
                endcase
                if (sym_err == ST_OK) begin
                    if (op == OP_SUB) sym_mode &= ~class_bits(who, perm);
                    else sym_mode |= class_bits(who, perm);
                end
            end
        end
        if (cnt != CNT_MAX) cnt++;
        if (it.last) begin
            res.res_mode = '0;
            res.status   = ST_OK;
            if (cnt == LEN_OCTAL && first_oct) begin
                if (oct_ok) res.res_mode = oct_val;
                else res.status = ST_BAD_FORMAT;
            end else if (cnt == LEN_LONG && ltr_set_ok) begin
                if (ltr_pos_ok) res.res_mode = ltr_bits;
                else res.status = ST_BAD_FORMAT;
            end else if (cnt == LEN_LONG && bin_ok) begin
                res.res_mode = bin_bits;
            end else if (sym_err != ST_OK) begin
                res.status = sym_err;
            end else if (!sym_rwx) begin
                res.status = ST_BAD_OP;
            end else begin
                res.res_mode = sym_mode;
            end
            if (res.status != ST_OK) res.res_mode = '0;
            mode_results_q.push_back(res);
            cnt = '0;
        end
    endtask

    task automatic add_char(input logic [CHAR_W-1:0] ch, input logic [MODE_W-1:0] base,
                            input bit fin, input bit drain);
        t_pending_char e;
        e.it.ch       = ch;
        e.it.cur_mode = base;
        e.it.last     = fin;
        e.drain       = drain;
        char_q.push_back(e);
    endtask

    task automatic add_bytes(input logic [CHAR_W-1:0] str[$], input logic [MODE_W-1:0] base,
                             input bit drain);
        for (int i = 0; i < str.size(); i++)
            add_char(str[i], (i == 0) ? base : MODE_W'($urandom_range(511)),
                     i == str.size() - 1, drain && i == 0);
    endtask

    task automatic add_str(input string s, input logic [MODE_W-1:0] base);
        logic [CHAR_W-1:0] str[$];
        for (int i = 0; i < s.len(); i++) str.push_back(s[i]);
        add_bytes(str, base, 1'b0);
    endtask

    task automatic add_random_string(input bit drain);
        logic [CHAR_W-1:0] str[$];
        string             who_set, op_set, perm_set, rwx_set;
        int unsigned       kind, n;
        who_set  = "ugoa";
        op_set   = "+-=";
        perm_set = "rwx";
        rwx_set  = "rwx-";
        kind     = $urandom_range(9);
        if (kind <= 1) begin
            for (int i = 0; i < 3; i++) str.push_back(CH_ZERO + CHAR_W'($urandom_range(7)));
            if ($urandom_range(5) == 0) str[$urandom_range(2, 1)] = CHAR_W'($urandom_range(255));
        end else if (kind <= 3) begin
            for (int i = 0; i < 9; i++)
                str.push_back($urandom_range(1) ? perm_set[i % 3] : CH_DASH);
            if ($urandom_range(5) == 0) str[$urandom_range(8)] = rwx_set[$urandom_range(3)];
        end else if (kind == 4) begin
            for (int i = 0; i < 9; i++) str.push_back($urandom_range(1) ? CH_ONE : CH_ZERO);
            if ($urandom_range(7) == 0) str[$urandom_range(8)] = CHAR_W'($urandom_range(255));
        end else if (kind <= 8) begin
            n = $urandom_range(3);
            for (int i = 0; i < n; i++) str.push_back(who_set[$urandom_range(3)]);
            if ($urandom_range(9) != 0) str.push_back(op_set[$urandom_range(2)]);
            n = ($urandom_range(7) == 0) ? $urandom_range(14) : $urandom_range(4);
            for (int i = 0; i < n; i++) str.push_back(perm_set[$urandom_range(2)]);
            if (str.size() == 0) str.push_back(who_set[$urandom_range(3)]);
            if ($urandom_range(7) == 0)
                str[$urandom_range(str.size() - 1)] = CHAR_W'($urandom_range(255));
        end else begin
            n = $urandom_range(16, 1);
            for (int i = 0; i < n; i++) str.push_back(CHAR_W'($urandom_range(255)));
        end
        add_bytes(str, MODE_W'($urandom_range(511)), drain);
    endtask

    // driver: one character per transfer, held until accepted
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            parse_mode_char(cur.it);
            chars_in++;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && chars_out == chars_in) begin
            if (char_q.size() != 0 && !(char_q[0].drain && mode_results_q.size() != 0)
                    && (no_idle() || $urandom_range(99) >= 14)) begin
                cur = char_q.pop_front();
                chars_out++;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'b0, cur.it.cur_mode, cur.it.ch};
                s_axis_tlast  <= cur.it.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(negedge i_clk) begin
        m_axis_tready <= no_idle() || $urandom_range(99) >= 14;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (mode_results_q.size() == 0) begin
                $display("%0t: result with none expected: mode %o status %0d", $time,
                         m_axis_tdata[8:0], m_axis_tdata[10:9]);
                n_err++;
            end else begin
                want = mode_results_q.pop_front();
                if (m_axis_tdata[8:0] !== want.res_mode) begin
                    $display("%0t: res_mode expected %o actual %o", $time,
                             want.res_mode, m_axis_tdata[8:0]);
                    n_err++;
                end
                if (m_axis_tdata[10:9] !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, m_axis_tdata[10:9]);
                    n_err++;
                end
            end
        end
    end

    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

    initial begin
        add_str("777", 9'o000);
        add_str("000", 9'o777);
        add_str("755", 9'o123);
        add_str("7a1", 9'o644);
        add_str("811", 9'o644);
        add_str("rwxr-x---", 9'o000);
        add_str("---------", 9'o777);
        add_str("wrx------", 9'o000);
        add_str("101010101", 9'o000);
        add_str("111111111", 9'o000);
        add_str("u+x", 9'o000);
        add_str("go-w", 9'o777);
        add_str("a=r", 9'o777);
        add_str("ug=", 9'o777);
        add_str("+x", 9'o644);
        add_str("=", 9'o751);
        add_str("ug", 9'o777);
        add_str("u+z", 9'o000);
        add_str("uz+q", 9'o000);
        add_char(8'h00, 9'o777, 1'b1, 1'b0);
        add_char(CH_O, 9'o000, 1'b0, 1'b0);
        add_char(CH_PLUS, 9'o777, 1'b0, 1'b0);
        add_char(8'hff, 9'o000, 1'b1, 1'b0);
        add_str("ugoa+rwxrwxrwxrwx", 9'o000);
        // random part, first string waits for the directed results to drain
        add_random_string(1'b1);
        while (char_q.size() < 800) add_random_string($urandom_range(39) == 0);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (char_q.size() != 0 || chars_out != chars_in || mode_results_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_err == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/pmsp_pkg.sv
src/pmsp_core.sv
src/permission_mode_string_parser_top.sv
verif/testbench.sv
